// ===== sv/joystick_direction_qualifier_assert.svh =====
// Assertion macros for the joystick direction qualifier.
// Used by joystick_direction_qualifier.sv; no other dependencies.
`ifndef JOYSTICK_DIRECTION_QUALIFIER_ASSERT_SVH
`define JOYSTICK_DIRECTION_QUALIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JDQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/jdq_pkg.sv =====
// Shared types and constants for the joystick direction qualifier.
// No dependencies.
`timescale 1ns / 1ps

package jdq_pkg;

   typedef enum logic [2:0] {
      DIR_STOP    = 3'd0,
      DIR_FORWARD = 3'd1,
      DIR_BACK    = 3'd2,
      DIR_LEFT    = 3'd3,
      DIR_RIGHT   = 3'd4
   } dir_type;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_DEADZONE_LIMIT      = 2'd0;
   localparam csr_index_type CSR_DIRECTION_THRESHOLD = 2'd1;
   localparam csr_index_type CSR_ENGAGE_LEVEL        = 2'd2;
   localparam csr_index_type CSR_HOLD_LEVEL          = 2'd3;

   localparam logic [15:0] DEADZONE_LIMIT_RESET      = 16'd4916;
   localparam logic [15:0] DIRECTION_THRESHOLD_RESET = 16'd9830;
   localparam logic [7:0]  ENGAGE_LEVEL_RESET        = 8'd180;
   localparam logic [7:0]  HOLD_LEVEL_RESET          = 8'd150;

   // Stick path result handed from the stick logic to the top level.
   typedef struct packed {
      logic signed [15:0] axis_x;
      logic signed [16:0] axis_y;
      dir_type            direction;
      logic               active;
   } stick_result_type;

endpackage

// ===== sv/jdq_stick.sv =====
// Stick path of the joystick direction qualifier: deadzone, vertical
// inversion and dominant axis direction. Depends on jdq_pkg.
`timescale 1ns / 1ps

module jdq_stick (
   input  logic signed [15:0]       stick_x,
   input  logic signed [15:0]       stick_y,
   input  logic [15:0]              deadzone_limit,
   input  logic [15:0]              direction_threshold,
   output jdq_pkg::stick_result_type result
);
   import jdq_pkg::*;

   logic signed [16:0] x_wide;
   logic signed [16:0] y_wide;
   logic [16:0]        x_mag;
   logic [16:0]        y_mag;
   logic               x_kept;
   logic               y_kept;
   logic signed [15:0] x_dz;
   logic signed [16:0] y_neg;
   logic [16:0]        ax;
   logic [16:0]        ay;
   logic [16:0]        threshold_wide;
   dir_type            direction;

   assign x_wide = {stick_x[15], stick_x};
   assign y_wide = {stick_y[15], stick_y};

   // The most negative input has a magnitude of 32768, which needs 17 bits.
   assign x_mag = stick_x[15] ? 17'(-x_wide) : 17'(x_wide);
   assign y_mag = stick_y[15] ? 17'(-y_wide) : 17'(y_wide);

   assign x_kept = !(x_mag < {1'b0, deadzone_limit});
   assign y_kept = !(y_mag < {1'b0, deadzone_limit});

   assign x_dz  = x_kept ? stick_x : 16'sd0;
   assign y_neg = y_kept ? 17'(-y_wide) : 17'sd0;

   assign ax = x_kept ? x_mag : 17'd0;
   assign ay = y_kept ? y_mag : 17'd0;
   assign threshold_wide = {1'b0, direction_threshold};

   // On a tie the vertical axis decides.
   always_comb begin
      direction = DIR_STOP;
      if (ax > ay) begin
         if (ax > threshold_wide) begin
            direction = x_dz[15] ? DIR_LEFT : DIR_RIGHT;
         end
      end else begin
         if (ay > threshold_wide) begin
            direction = y_neg[16] ? DIR_FORWARD : DIR_BACK;
         end
      end
   end

   assign result.axis_x    = x_dz;
   assign result.axis_y    = y_neg;
   assign result.direction = direction;
   // A zero axis passes a zero deadzone, so activity looks at the values themselves.
   assign result.active    = (x_dz != 16'sd0) || (y_neg != 17'sd0);

endmodule

// ===== sv/jdq_trigger.sv =====
// Press/release hysteresis for one analog trigger with rising edge report.
// No package dependencies; holds its own state.
`timescale 1ns / 1ps

module jdq_trigger (
   input  logic       clock,
   input  logic       reset,
   input  logic       connected,
   input  logic       advance,
   input  logic [7:0] level,
   input  logic [7:0] engage_level,
   input  logic [7:0] hold_level,
   output logic       rise
);
   logic held_ff;
   logic held_in;
   logic pressed;

   assign pressed = held_ff ? (level > hold_level) : (level > engage_level);
   assign rise    = connected && pressed && !held_ff;

   // A disconnected poll leaves the held state alone.
   assign held_in = (advance && connected) ? pressed : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
   end

endmodule

// ===== sv/joystick_direction_qualifier.sv =====
// Joystick direction qualifier. Each request transaction is one controller
// poll; each poll yields exactly one response transaction. A poll is taken
// into an input register, evaluated by the stick and trigger logic, and the
// response lands in an output register. One poll is accepted every clock while
// the response side keeps up; req_stall follows rsp_stall in the same cycle
// when both registers are full. The user must write configuration registers
// only while no poll is in flight; the block does not enforce this. Depends on
// jdq_pkg, jdq_stick, jdq_trigger and joystick_direction_qualifier_assert.svh.
`timescale 1ns / 1ps
`include "joystick_direction_qualifier_assert.svh"

module joystick_direction_qualifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [jdq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [jdq_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_connected,
   input  logic signed [15:0]                 req_stick_x,
   input  logic signed [15:0]                 req_stick_y,
   input  logic [7:0]                         req_left_trigger,
   input  logic [7:0]                         req_right_trigger,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [15:0]                 rsp_axis_x,
   output logic signed [16:0]                 rsp_axis_y,
   output logic [2:0]                         rsp_direction,
   output logic                               rsp_direction_changed,
   output logic                               rsp_stick_active,
   output logic                               rsp_active_changed,
   output logic                               rsp_slow_down_event,
   output logic                               rsp_speed_up_event
);
   import jdq_pkg::*;

   // Configuration registers.
   logic [15:0] deadzone_limit_ff;
   logic [15:0] direction_threshold_ff;
   logic [7:0]  engage_level_ff;
   logic [7:0]  hold_level_ff;

   // Input register.
   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic               s1_connected_ff;
   logic signed [15:0] s1_stick_x_ff;
   logic signed [15:0] s1_stick_y_ff;
   logic [7:0]         s1_left_trigger_ff;
   logic [7:0]         s1_right_trigger_ff;

   // Poll state.
   dir_type last_dir_ff;
   dir_type last_dir_in;
   logic    active_ff;
   logic    active_in;

   // Output register.
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic signed [15:0] rsp_axis_x_ff;
   logic signed [16:0] rsp_axis_y_ff;
   dir_type            rsp_direction_ff;
   logic               rsp_direction_changed_ff;
   logic               rsp_stick_active_ff;
   logic               rsp_active_changed_ff;
   logic               rsp_slow_down_event_ff;
   logic               rsp_speed_up_event_ff;

   logic               req_accept;
   logic               out_free;
   logic               s1_advance;
   stick_result_type   stick;
   logic               left_rise;
   logic               right_rise;

   logic signed [15:0] res_axis_x;
   logic signed [16:0] res_axis_y;
   dir_type            res_direction;
   logic               res_direction_changed;
   logic               res_stick_active;
   logic               res_active_changed;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_limit_ff      <= DEADZONE_LIMIT_RESET;
         direction_threshold_ff <= DIRECTION_THRESHOLD_RESET;
         engage_level_ff        <= ENGAGE_LEVEL_RESET;
         hold_level_ff          <= HOLD_LEVEL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEADZONE_LIMIT: begin
               deadzone_limit_ff <= csr_data[15:0];
            end
            CSR_DIRECTION_THRESHOLD: begin
               direction_threshold_ff <= csr_data[15:0];
            end
            CSR_ENGAGE_LEVEL: begin
               engage_level_ff <= csr_data[7:0];
            end
            CSR_HOLD_LEVEL: begin
               hold_level_ff <= csr_data[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_connected_ff     <= req_connected;
         s1_stick_x_ff       <= req_stick_x;
         s1_stick_y_ff       <= req_stick_y;
         s1_left_trigger_ff  <= req_left_trigger;
         s1_right_trigger_ff <= req_right_trigger;
      end
   end

   jdq_stick u_stick (
      .stick_x             (s1_stick_x_ff),
      .stick_y             (s1_stick_y_ff),
      .deadzone_limit      (deadzone_limit_ff),
      .direction_threshold (direction_threshold_ff),
      .result              (stick)
   );

   jdq_trigger u_left (
      .clock        (clock),
      .reset        (reset),
      .connected    (s1_connected_ff),
      .advance      (s1_advance),
      .level        (s1_left_trigger_ff),
      .engage_level (engage_level_ff),
      .hold_level   (hold_level_ff),
      .rise         (left_rise)
   );

   jdq_trigger u_right (
      .clock        (clock),
      .reset        (reset),
      .connected    (s1_connected_ff),
      .advance      (s1_advance),
      .level        (s1_right_trigger_ff),
      .engage_level (engage_level_ff),
      .hold_level   (hold_level_ff),
      .rise         (right_rise)
   );

   // A disconnected poll forces stop and repeats the stored active flag.
   always_comb begin
      if (s1_connected_ff) begin
         res_axis_x         = stick.axis_x;
         res_axis_y         = stick.axis_y;
         res_direction      = stick.direction;
         res_stick_active   = stick.active;
         res_active_changed = stick.active != active_ff;
      end else begin
         res_axis_x         = 16'sd0;
         res_axis_y         = 17'sd0;
         res_direction      = DIR_STOP;
         res_stick_active   = active_ff;
         res_active_changed = 1'b0;
      end
      res_direction_changed = res_direction != last_dir_ff;
   end

   assign last_dir_in = s1_advance ? res_direction : last_dir_ff;
   assign active_in   = (s1_advance && s1_connected_ff) ? stick.active : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_dir_ff <= DIR_STOP;
         active_ff   <= 1'b0;
      end else begin
         last_dir_ff <= last_dir_in;
         active_ff   <= active_in;
      end
   end

   always_comb begin
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_axis_x_ff            <= res_axis_x;
         rsp_axis_y_ff            <= res_axis_y;
         rsp_direction_ff         <= res_direction;
         rsp_direction_changed_ff <= res_direction_changed;
         rsp_stick_active_ff      <= res_stick_active;
         rsp_active_changed_ff    <= res_active_changed;
         rsp_slow_down_event_ff   <= left_rise;
         rsp_speed_up_event_ff    <= right_rise;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_axis_x            = rsp_axis_x_ff;
   assign rsp_axis_y            = rsp_axis_y_ff;
   assign rsp_direction         = rsp_direction_ff;
   assign rsp_direction_changed = rsp_direction_changed_ff;
   assign rsp_stick_active      = rsp_stick_active_ff;
   assign rsp_active_changed    = rsp_active_changed_ff;
   assign rsp_slow_down_event   = rsp_slow_down_event_ff;
   assign rsp_speed_up_event    = rsp_speed_up_event_ff;

   // The stored direction always matches the most recent response.
   `JDQ_ASSERT_SAME(a_last_dir_tracks_rsp, clock, reset, rsp_valid_ff,
      rsp_direction_ff == last_dir_ff, "stored direction differs from response")
   `JDQ_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, s1_advance,
      rsp_valid_ff, "evaluated poll did not reach the output register")
   `JDQ_ASSERT_SAME(a_empty_input_no_stall, clock, reset, !s1_valid_ff,
      !req_stall, "request stalled while the input register is empty")
   `JDQ_ASSERT_SAME(a_nonzero_axis_active, clock, reset,
      rsp_valid_ff && (rsp_axis_x_ff != 16'sd0 || rsp_axis_y_ff != 17'sd0),
      rsp_stick_active_ff, "nonzero axis reported with the stick inactive")
   `JDQ_ASSERT_SAME(a_direction_needs_active, clock, reset,
      rsp_valid_ff && rsp_direction_ff != DIR_STOP,
      rsp_stick_active_ff, "direction reported with the stick inactive")

endmodule
